// File: rtl/smartcard_character_receiver_unit_assert.svh
// Assertion macros used by the checker file of the smartcard receiver.
`ifndef SMARTCARD_CHARACTER_RECEIVER_UNIT_ASSERT_SVH
`define SMARTCARD_CHARACTER_RECEIVER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SCR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scr assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SCR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scr assertion failed");

`endif

// File: rtl/scr_pkg.sv
// Shared types and constants of the smartcard character receiver.
`default_nettype none

package scr_pkg;

	localparam int DATA_BITS = 8;
	localparam int BIT_W     = $clog2(DATA_BITS);
	localparam int ETU_W     = 13;
	localparam int CHAR_W    = 8;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 8;
	localparam int OUT_TUSER_W = 2;

	localparam logic [ETU_W-1:0] ETU_RESET = ETU_W'(744);

	typedef enum logic [4:0] {
		PH_IDLE   = 5'b00001,
		PH_START  = 5'b00010,
		PH_DATA   = 5'b00100,
		PH_PARITY = 5'b01000,
		PH_STOP   = 5'b10000
	} frame_phase_t;

	typedef struct packed {
		logic rst_level;
		logic io_level;
		logic clk_level;
	} line_sample_t;

	typedef struct packed {
		logic              valid;
		logic [CHAR_W-1:0] char_byte;
		logic              parity_error;
		logic              framing_error;
	} char_result_t;

endpackage

`default_nettype wire

// File: rtl/scr_frame.sv
// Character framing state: edge counting, bit sampling, parity and stop check.
`default_nettype none

module scr_frame import scr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  line_sample_t      sample,
	input  logic [ETU_W-1:0]  edges_per_etu,
	output char_result_t      result
);

	frame_phase_t           phase_q, phase_d;
	logic                   prev_clk_q, prev_clk_d;
	logic                   prev_io_q, prev_io_d;
	logic                   prev_rst_q, prev_rst_d;
	logic                   armed_q, armed_d;
	logic [ETU_W-1:0]       edge_count_q, edge_count_d;
	logic [BIT_W-1:0]       bit_index_q, bit_index_d;
	logic [DATA_BITS-1:0]   shift_q, shift_d;
	logic                   parity_q, parity_d;

	logic                   clk_edge;
	logic                   io_edge;
	logic [ETU_W-1:0]       target_raw;
	logic [ETU_W-1:0]       target;
	logic [ETU_W-1:0]       count_inc;
	logic                   sample_pt;
	logic                   last_bit;

	always_comb begin
		phase_d      = phase_q;
		prev_clk_d   = sample.clk_level;
		prev_io_d    = sample.io_level;
		prev_rst_d   = sample.rst_level;
		armed_d      = armed_q;
		edge_count_d = edge_count_q;
		bit_index_d  = bit_index_q;
		shift_d      = shift_q;
		parity_d     = parity_q;
		result       = '0;

		clk_edge   = sample.clk_level != prev_clk_q;
		io_edge    = sample.io_level != prev_io_q;
		// half an etu for the start bit, a full etu after that, never below one edge
		target_raw = (phase_q == PH_START) ? {1'b0, edges_per_etu[ETU_W-1:1]} : edges_per_etu;
		target     = (target_raw == '0) ? ETU_W'(1) : target_raw;
		count_inc  = edge_count_q + ETU_W'(1);
		sample_pt  = count_inc >= target;
		last_bit   = ({1'b0, bit_index_q} + (BIT_W+1)'(1)) >= (BIT_W+1)'(DATA_BITS);

		if (phase_q == PH_IDLE) begin
			if (armed_q && io_edge) begin
				phase_d      = PH_START;
				edge_count_d = '0;
				bit_index_d  = '0;
				shift_d      = '0;
				parity_d     = 1'b0;
			end else if (!armed_q && sample.rst_level && !prev_rst_q) begin
				armed_d = 1'b1;
			end
		end else if (clk_edge) begin
			edge_count_d = count_inc;
			if (sample_pt) begin
				edge_count_d = '0;
				case (phase_q)
					PH_START: begin
						phase_d     = PH_DATA;
						bit_index_d = '0;
					end
					PH_DATA: begin
						shift_d = {sample.io_level, shift_q[DATA_BITS-1:1]};
						if (last_bit) begin
							bit_index_d = '0;
							phase_d     = PH_PARITY;
						end else begin
							bit_index_d = bit_index_q + BIT_W'(1);
						end
					end
					PH_PARITY: begin
						parity_d = (^shift_q) ^ sample.io_level;
						phase_d  = PH_STOP;
					end
					PH_STOP: begin
						result.valid         = 1'b1;
						result.char_byte     = CHAR_W'(shift_q);
						result.parity_error  = parity_q;
						result.framing_error = ~sample.io_level;
						phase_d              = PH_IDLE;
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			prev_clk_q   <= 1'b0;
			prev_io_q    <= 1'b1;
			prev_rst_q   <= 1'b0;
			armed_q      <= 1'b0;
			edge_count_q <= '0;
			bit_index_q  <= '0;
			shift_q      <= '0;
			parity_q     <= 1'b0;
		end else if (step_en) begin
			phase_q      <= phase_d;
			prev_clk_q   <= prev_clk_d;
			prev_io_q    <= prev_io_d;
			prev_rst_q   <= prev_rst_d;
			armed_q      <= armed_d;
			edge_count_q <= edge_count_d;
			bit_index_q  <= bit_index_d;
			shift_q      <= shift_d;
			parity_q     <= parity_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/smartcard_character_receiver_unit.sv
// Path: a beat lands in the input register, then advances into the framing state, and the
// character whose stop bit it samples is registered into the output slot on the master side.
// Throughput: one line-sample beat per cycle; a held result stalls intake only while
// m_tready is low. Reset (arst_n low) resets the line history and framing state, clears both
// valid flags and sets edges_per_etu to 744; the block then waits for a reset-line rise.
// Top level of the smartcard character receiver.
`default_nettype none

module smartcard_character_receiver_unit import scr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration: edges_per_etu
	input  logic                   cfg_we,
	input  logic [ETU_W-1:0]       cfg_wdata,
	// line samples
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [0] clk_level, [1] io_level, [2] rst_level
	// received characters
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] char_byte
	output logic [OUT_TUSER_W-1:0] m_tuser    // [0] parity_error, [1] framing_error
);

	logic [ETU_W-1:0]  etu_q;
	logic              valid_s1;
	line_sample_t      sample_s1;
	logic              advance;
	char_result_t      result;
	logic              out_valid_q;
	logic [CHAR_W-1:0] out_byte_q;
	logic              out_perr_q;
	logic              out_ferr_q;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			etu_q <= ETU_RESET;
		end else if (cfg_we) begin
			etu_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_s1.clk_level <= s_tdata[0];
			sample_s1.io_level  <= s_tdata[1];
			sample_s1.rst_level <= s_tdata[2];
		end
	end

	scr_frame u_frame (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_en       (advance),
		.sample        (sample_s1),
		.edges_per_etu (etu_q),
		.result        (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && result.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the character until its beat is taken
	always_ff @(posedge clk) begin
		if (advance && result.valid) begin
			out_byte_q <= result.char_byte;
			out_perr_q <= result.parity_error;
			out_ferr_q <= result.framing_error;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'(out_byte_q);
	assign m_tuser  = {out_ferr_q, out_perr_q};

endmodule

`default_nettype wire

// File: rtl/scr_checker.sv
// Port-level checker for the smartcard character receiver, bound to the top level.
`default_nettype none

`include "smartcard_character_receiver_unit_assert.svh"

module scr_checker import scr_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic [OUT_TUSER_W-1:0] m_tuser
);

	// a free or draining output slot never blocks intake
	`SCR_ASSERT_NOW(a_ready_when_room, !m_tvalid || m_tready, s_tready)

	// a stalled character beat keeps its payload
	`SCR_ASSERT_NEXT(a_hold_stalled, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// a new character needs a sample beat taken into the input register ahead of it
	`SCR_ASSERT_NOW(a_result_from_beat, $rose(m_tvalid), $past(s_tvalid && s_tready, 2))

	// a taken character while intake is stalled leaves the output empty
	`SCR_ASSERT_NEXT(a_no_repeat, m_tvalid && m_tready && !s_tready, !m_tvalid)

endmodule

bind smartcard_character_receiver_unit scr_checker u_scr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
